@@ src/sppt_pkg.sv @@
// Shared types, constants and helpers for the spectral plateau pitch tracker.
// No dependencies; every other file in src imports this package.
package sppt_pkg;

  localparam int NumBins   = 134;
  localparam int BinW      = 8;
  localparam int FreqW     = 22;
  localparam int MagW      = 24;
  localparam int CfgW      = 21;
  localparam int CfgIdxW   = 3;
  localparam int SumW      = 32;
  localparam int WsumW     = 56;
  localparam int DivW      = 56;
  localparam int DivisorW  = 32;
  localparam int DivCntW   = 6;
  localparam int QDepth    = 4;
  localparam int QPtrW     = 2;
  localparam int QCntW     = 3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_THRESH  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_FMIN_LO = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_FMIN_HI = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_FMAX_LO = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_FMAX_HI = 3'd4;

  // Operation codes passed from front to back
  localparam logic [1:0] OP_ADD   = 2'd0;  // accumulate into open run
  localparam logic [1:0] OP_START = 2'd1;  // open run and accumulate
  localparam logic [1:0] OP_CLOSE = 2'd2;  // close run ending at idx
  localparam logic [1:0] OP_MARK  = 2'd3;  // bare frame-end marker

  typedef struct packed {
    logic [1:0]             kind;
    logic [BinW-1:0]        idx;
    logic signed [FreqW-1:0] freq;
    logic [MagW-1:0]        mag;
    logic                   fe;
  } op_t;

  typedef struct packed {
    logic [CfgW-1:0] thresh;
    logic [CfgW-1:0] fmin_lo;
    logic [CfgW-1:0] fmin_hi;
    logic [CfgW-1:0] fmax_lo;
    logic [CfgW-1:0] fmax_hi;
  } cfg_t;

  // Flat when the absolute difference is strictly below the threshold
  function automatic logic is_flat(logic signed [FreqW-1:0] a,
                                   logic signed [FreqW-1:0] b,
                                   logic [CfgW-1:0] thr);
    logic [FreqW:0] d;
    logic [FreqW:0] m;
    d = {a[FreqW-1], a} - {b[FreqW-1], b};
    m = d[FreqW] ? (~d + 1'b1) : d;
    return m < {2'b00, thr};
  endfunction

endpackage

@@ src/sppt_fifo.sv @@
// Short operation queue between the front classifier and the back datapath.
// Depends on sppt_pkg (op_t, queue depth).
module sppt_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  sppt_pkg::op_t  push_op_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output sppt_pkg::op_t  pop_op_o
);
  import sppt_pkg::*;

  op_t              mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != QCntW'(QDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_op_o     = mem_q[rd_q];
  assign push = push_valid_i & push_ready_o;
  assign pop  = pop_valid_o & pop_ready_i;

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_op_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + QCntW'(push) - QCntW'(pop);
    end
  end

endmodule

@@ src/sppt_front.sv @@
// Front part: accepts bins, decides bin goodness and run boundaries, and
// issues run operations one per cycle while the queue takes them. Depends on sppt_pkg.
module sppt_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [sppt_pkg::FreqW-1:0]  if_value_i,
  input  logic [sppt_pkg::MagW-1:0]          magnitude_i,
  input  logic [sppt_pkg::CfgW-1:0]          thresh_i,
  output logic                               op_valid_o,
  input  logic                               op_ready_i,
  output sppt_pkg::op_t                      op_o
);
  import sppt_pkg::*;

  logic [BinW-1:0]         cnt_q;
  logic signed [FreqW-1:0] pf0_q, pf1_q;
  logic [MagW-1:0]         pm0_q, pm1_q;
  logic [1:0]              gh_q;
  logic                    open_q;
  logic                    busy_q;
  logic [1:0]              ptr_q;
  op_t                     slot_q [4];
  logic [3:0]              slot_v_q;

  logic       accept, last, ge2, g, g01, d2, d1, d0;
  logic       c0, c1, c2, c3;
  op_t        slot_d [4];
  logic [3:0] slot_v_d;
  logic       adv;

  function automatic op_t bin_op(logic d, logic open_b, logic [BinW-1:0] idx,
                                 logic signed [FreqW-1:0] f, logic [MagW-1:0] mag);
    op_t o;
    o = '0;
    if (d) begin
      o.kind = open_b ? OP_ADD : OP_START;
      o.idx  = idx;
      o.freq = f;
      o.mag  = mag;
    end else begin
      o.kind = OP_CLOSE;
      o.idx  = idx - 1'b1;
    end
    return o;
  endfunction

  assign in_ready_o = !busy_q;
  assign accept     = in_valid_i & in_ready_o;

  // Classify the incoming bin against the held neighbors
  always_comb begin
    last = (cnt_q == BinW'(NumBins - 1));
    ge2  = (cnt_q >= 8'd2);
    g    = is_flat(if_value_i, pf1_q, thresh_i);
    g01  = is_flat(if_value_i, pf0_q, thresh_i);
    d2   = (cnt_q == 8'd2) ? gh_q[0] : (gh_q[0] & (g | gh_q[1]));
    d1   = g & (g01 | gh_q[0]);
    d0   = g01;
    c0   = !d2 & open_q;
    c1   = !d1 & d2;
    c2   = !d0 & d1;
    c3   = d0;

    slot_d[0]    = bin_op(d2, open_q, cnt_q - 8'd2, pf1_q, pm1_q);
    slot_d[0].fe = last & c0 & !c1 & !c2 & !c3;
    slot_v_d[0]  = ge2 & (d2 | open_q);

    slot_d[1]    = bin_op(d1, d2, cnt_q - 8'd1, pf0_q, pm0_q);
    slot_d[1].fe = c1 & !c2 & !c3;
    slot_v_d[1]  = last & (d1 | d2);

    slot_d[2]    = bin_op(d0, d1, cnt_q, if_value_i, magnitude_i);
    slot_d[2].fe = c2 & !c3;
    slot_v_d[2]  = last & (d0 | d1);

    // Close the final run at the last bin, or mark the frame end when no run closes there
    slot_d[3]      = '0;
    slot_d[3].kind = d0 ? OP_CLOSE : OP_MARK;
    slot_d[3].idx  = d0 ? cnt_q : '0;
    slot_d[3].fe   = 1'b1;
    slot_v_d[3]    = last & (d0 | !(c0 | c1 | c2));
  end

  assign op_valid_o = busy_q & slot_v_q[ptr_q];
  assign op_o       = slot_q[ptr_q];
  assign adv        = busy_q & (!slot_v_q[ptr_q] | op_ready_i);

  // Hold the operation slots of the accepted transaction
  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < 4; i++) slot_q[i] <= slot_d[i];
    end
  end

  // Track bin history and issue slots
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      pf0_q    <= '0;
      pf1_q    <= '0;
      pm0_q    <= '0;
      pm1_q    <= '0;
      gh_q     <= '0;
      open_q   <= 1'b0;
      busy_q   <= 1'b0;
      ptr_q    <= '0;
      slot_v_q <= '0;
    end else begin
      if (accept) begin
        busy_q   <= 1'b1;
        ptr_q    <= '0;
        slot_v_q <= slot_v_d;
        if (last) begin
          cnt_q  <= '0;
          pf0_q  <= '0;
          pf1_q  <= '0;
          pm0_q  <= '0;
          pm1_q  <= '0;
          gh_q   <= '0;
          open_q <= 1'b0;
        end else begin
          if (cnt_q == 8'd1) gh_q <= {1'b0, g01};
          else if (ge2)      gh_q <= {gh_q[0], g};
          if (ge2) open_q <= d2;
          pf1_q <= pf0_q;
          pf0_q <= if_value_i;
          pm1_q <= pm0_q;
          pm0_q <= magnitude_i;
          cnt_q <= cnt_q + 1'b1;
        end
      end else if (adv) begin
        ptr_q <= ptr_q + 1'b1;
        if (ptr_q == 2'd3) busy_q <= 1'b0;
      end
    end
  end

endmodule

@@ src/sppt_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by the back part.
// Depends on sppt_pkg for widths.
module sppt_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [sppt_pkg::DivW-1:0]         dividend_i,
  input  logic [sppt_pkg::DivisorW-1:0]     divisor_i,
  output logic                              done_o,
  output logic [sppt_pkg::DivW-1:0]         quot_o
);
  import sppt_pkg::*;

  logic                busy_q, done_q;
  logic [DivCntW-1:0]  cnt_q;
  logic [DivisorW-1:0] rem_q, dsr_q;
  logic [DivW-1:0]     quo_q;
  logic [DivisorW:0]   sh;
  logic                ge;

  assign sh     = {rem_q, quo_q[DivW-1]};
  assign ge     = (sh >= {1'b0, dsr_q});
  assign done_o = done_q;
  assign quot_o = quo_q;

  // Shift in one dividend bit and subtract when it fits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? DivisorW'(sh - {1'b0, dsr_q}) : sh[DivisorW-1:0];
      quo_q <= {quo_q[DivW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DivW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

@@ src/sppt_back.sv @@
// Back part: accumulates runs, divides out the peak frequency, applies the
// band fades and drives the result register. Depends on sppt_pkg, sppt_div.
module sppt_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          op_valid_i,
  output logic                          op_ready_o,
  input  sppt_pkg::op_t                 op_i,
  input  sppt_pkg::cfg_t                cfg_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          peak_valid_o,
  output logic [sppt_pkg::BinW-1:0]     peak_bin_o,
  output logic [sppt_pkg::CfgW-1:0]     peak_freq_o,
  output logic [sppt_pkg::SumW-1:0]     peak_mag_o,
  output logic                          frame_end_o
);
  import sppt_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_ACC   = 3'd2;
  localparam logic [2:0] S_DIVGO = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_CHK   = 3'd5;
  localparam logic [2:0] S_LOW   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  localparam logic [1:0] PH_FREQ = 2'd0;
  localparam logic [1:0] PH_HIGH = 2'd1;
  localparam logic [1:0] PH_LOW  = 2'd2;

  logic [2:0]      state_q;
  op_t             op_q;
  logic [1:0]      ph_q;
  logic [BinW-1:0] start_q;
  logic [SumW-1:0] msum_q;
  logic [WsumW-1:0] wsum_q;
  logic [DivW-1:0] prod_q;
  logic [DivW-1:0] q_q;
  logic [CfgW-1:0] den_q;
  logic [SumW-1:0] m_q;
  logic [CfgW-1:0] fq_q;
  logic [BinW-1:0] bin_q;
  logic            pv_q, fe_q;
  logic            out_valid_q, out_pv_q, out_fe_q;
  logic [BinW-1:0] out_bin_q;
  logic [CfgW-1:0] out_freq_q;
  logic [SumW-1:0] out_mag_q;

  logic signed [FreqW+MagW:0] mf;
  logic [WsumW-1:0]    wabs;
  logic [DivW-1:0]     dvd;
  logic [DivisorW-1:0] dsr;
  logic                div_done;
  logic [DivW-1:0]     div_quot;
  logic [BinW:0]       psum, pinc;
  logic [CfgW-1:0]     q21;
  logic [CfgW-1:0]     fade_k;
  logic [SumW+CfgW-1:0] fm;
  logic                out_free;

  assign op_ready_o = (state_q == S_IDLE);
  assign mf   = $signed({1'b0, op_q.mag}) * $signed(op_q.freq);
  assign wabs = wsum_q[WsumW-1] ? (~wsum_q + 1'b1) : wsum_q;
  assign dvd  = (ph_q == PH_FREQ) ? wabs : prod_q;
  assign dsr  = (ph_q == PH_FREQ) ? ((msum_q == '0) ? DivisorW'(1) : msum_q)
                                  : DivisorW'(den_q);
  assign psum = {1'b0, start_q} + {1'b0, op_i.idx};
  assign pinc = psum + 1'b1;
  assign q21  = q_q[CfgW-1:0];
  assign fade_k = (state_q == S_CHK) ? (cfg_i.fmax_hi - q21) : (fq_q - cfg_i.fmin_lo);
  assign fm   = (SumW+CfgW)'(m_q) * (SumW+CfgW)'(fade_k);
  assign out_free = !out_valid_q | out_ready_i;

  sppt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_DIVGO),
    .dividend_i (dvd),
    .divisor_i  (dsr),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Sequence run operations through the datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ph_q    <= PH_FREQ;
      start_q <= '0;
      msum_q  <= '0;
      wsum_q  <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (op_valid_i) begin
            op_q <= op_i;
            fe_q <= op_i.fe;
            case (op_i.kind)
              OP_ADD, OP_START: state_q <= S_MUL;
              OP_CLOSE: begin
                ph_q    <= PH_FREQ;
                m_q     <= msum_q;
                pv_q    <= 1'b1;
                bin_q   <= (psum == 9'd1) ? '0 : pinc[BinW:1];
                state_q <= S_DIVGO;
              end
              default: begin
                pv_q    <= 1'b0;
                bin_q   <= '0;
                fq_q    <= '0;
                m_q     <= '0;
                state_q <= S_OUT;
              end
            endcase
          end
        end
        S_MUL: begin
          prod_q <= DivW'(mf);
          if (op_q.kind == OP_START) begin
            start_q <= op_q.idx;
            msum_q  <= '0;
            wsum_q  <= '0;
          end
          state_q <= S_ACC;
        end
        S_ACC: begin
          msum_q  <= msum_q + SumW'(op_q.mag);
          wsum_q  <= wsum_q + prod_q;
          state_q <= S_IDLE;
        end
        S_DIVGO: state_q <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            case (ph_q)
              PH_FREQ: begin
                q_q     <= div_quot;
                state_q <= S_CHK;
              end
              PH_HIGH: begin
                m_q     <= div_quot[SumW-1:0];
                state_q <= S_LOW;
              end
              default: begin
                m_q     <= div_quot[SumW-1:0];
                state_q <= S_OUT;
              end
            endcase
          end
        end
        S_CHK: begin
          // Drop negative or too high peaks, fade above fmax_lower
          if ((wsum_q[WsumW-1] && q_q != '0) || q_q > DivW'(cfg_i.fmax_hi)) begin
            fq_q    <= '0;
            m_q     <= '0;
            state_q <= S_OUT;
          end else begin
            fq_q <= q21;
            if (q_q > DivW'(cfg_i.fmax_lo)) begin
              prod_q  <= DivW'(fm);
              den_q   <= cfg_i.fmax_hi - cfg_i.fmax_lo;
              ph_q    <= PH_HIGH;
              state_q <= S_DIVGO;
            end else begin
              state_q <= S_LOW;
            end
          end
        end
        S_LOW: begin
          // Drop too low peaks, fade below fmin_upper
          if (fq_q < cfg_i.fmin_lo) begin
            fq_q    <= '0;
            m_q     <= '0;
            state_q <= S_OUT;
          end else if (fq_q < cfg_i.fmin_hi) begin
            prod_q  <= DivW'(fm);
            den_q   <= cfg_i.fmin_hi - cfg_i.fmin_lo;
            ph_q    <= PH_LOW;
            state_q <= S_DIVGO;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Result register: load a finished peak or frame marker, hold it until taken
  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_free) begin
      out_pv_q   <= pv_q;
      out_bin_q  <= bin_q;
      out_freq_q <= fq_q;
      out_mag_q  <= m_q;
      out_fe_q   <= fe_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign peak_valid_o = out_pv_q;
  assign peak_bin_o   = out_bin_q;
  assign peak_freq_o  = out_freq_q;
  assign peak_mag_o   = out_mag_q;
  assign frame_end_o  = out_fe_q;

endmodule

@@ src/spectral_plateau_pitch_tracker_core.sv @@
// Top level of the spectral plateau pitch tracker: configuration registers,
// front classifier, operation queue and back datapath. Depends on sppt_pkg,
// sppt_front, sppt_fifo and sppt_back.
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o   if_value_i, magnitude_i
//   out      output     out_valid_o / out_ready_i peak_*_o, frame_end_o
//   cfg      input      cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// The front takes a bin and then issues up to four queued operations, one
// per cycle while the queue has room. The back steps each accumulated bin
// through its idle, multiply and accumulate states. A closing run costs up
// to three passes through the shared divider; with the state steps around
// them, a closing run sets the worst case.
// Reset clears all control state; no clearing pass is needed. Each side
// stalls on its own behind the queue and the result register.
module spectral_plateau_pitch_tracker_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [sppt_pkg::FreqW-1:0]  if_value_i,
  input  logic [sppt_pkg::MagW-1:0]          magnitude_i,
  input  logic                               cfg_we_i,
  input  logic [sppt_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [sppt_pkg::CfgW-1:0]          cfg_wdata_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               peak_valid_o,
  output logic [sppt_pkg::BinW-1:0]          peak_bin_o,
  output logic [sppt_pkg::CfgW-1:0]          peak_freq_o,
  output logic [sppt_pkg::SumW-1:0]          peak_mag_o,
  output logic                               frame_end_o
);
  import sppt_pkg::*;

  cfg_t cfg_q;
  logic fr_valid, fr_ready, bk_valid, bk_ready;
  op_t  fr_op, bk_op;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.thresh  <= 21'd2000;
      cfg_q.fmin_lo <= 21'd12800;
      cfg_q.fmin_hi <= 21'd25600;
      cfg_q.fmax_lo <= 21'd134400;
      cfg_q.fmax_hi <= 21'd268800;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_THRESH:  cfg_q.thresh  <= cfg_wdata_i;
        CFG_FMIN_LO: cfg_q.fmin_lo <= cfg_wdata_i;
        CFG_FMIN_HI: cfg_q.fmin_hi <= cfg_wdata_i;
        CFG_FMAX_LO: cfg_q.fmax_lo <= cfg_wdata_i;
        CFG_FMAX_HI: cfg_q.fmax_hi <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  sppt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .if_value_i  (if_value_i),
    .magnitude_i (magnitude_i),
    .thresh_i    (cfg_q.thresh),
    .op_valid_o  (fr_valid),
    .op_ready_i  (fr_ready),
    .op_o        (fr_op)
  );

  sppt_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_op_i    (fr_op),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_op_o     (bk_op)
  );

  sppt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_valid_i   (bk_valid),
    .op_ready_o   (bk_ready),
    .op_i         (bk_op),
    .cfg_i        (cfg_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .peak_valid_o (peak_valid_o),
    .peak_bin_o   (peak_bin_o),
    .peak_freq_o  (peak_freq_o),
    .peak_mag_o   (peak_mag_o),
    .frame_end_o  (frame_end_o)
  );

endmodule
